>>> rtl/core/linked_buffer_free_list_defines.svh
// Assertion macros for the linked buffer free list.
// Depends on nothing; included by the top level only.
`ifndef LINKED_BUFFER_FREE_LIST_DEFINES_SVH
`define LINKED_BUFFER_FREE_LIST_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define LBFL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("linked buffer free list: same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LBFL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("linked buffer free list: next-cycle check failed");

`endif

>>> rtl/core/lbfl_pkg.sv
// Shared types and constants for the linked buffer free list.
// Used by lbfl_ctrl, lbfl_dp and linked_buffer_free_list; depends on nothing.
package lbfl_pkg;

    localparam int NUM_BUFFERS  = 256;
    localparam int HEADER_BYTES = 20;
    localparam int POOL_DEPTH   = 256;

    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int CAP_W  = 16;
    localparam int SPAN_W = CAP_W + 1;
    localparam int OFF_W  = 25;
    localparam int FLT_W  = 10;
    localparam int IN_W   = 16;
    localparam int OUT_W  = 56;

    // Largest count an initialize can chain
    localparam int POOL_LIMIT_INT = (NUM_BUFFERS < POOL_DEPTH) ? NUM_BUFFERS : POOL_DEPTH;
    localparam logic [CNT_W-1:0] POOL_LIMIT = CNT_W'(POOL_LIMIT_INT);

    localparam logic [IDX_W-1:0] TAIL_RESET = IDX_W'((NUM_BUFFERS - 1) % POOL_DEPTH);

    localparam logic [CNT_W-1:0]        FREE_MAX   = 9'd256;
    localparam logic signed [FLT_W-1:0] FLIGHT_MAX = 10'sd256;
    localparam logic signed [FLT_W-1:0] FLIGHT_MIN = -10'sd256;

    localparam logic [CNT_W-1:0] COUNT_RESET    = 9'd256;
    localparam logic [CAP_W-1:0] CAPACITY_RESET = 16'd4096;

    typedef enum logic [1:0] {
        REQ_ALLOC   = 2'd0,
        REQ_RELEASE = 2'd1,
        REQ_INIT    = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    typedef enum logic {
        CFG_BUFFER_COUNT    = 1'b0,
        CFG_BUFFER_CAPACITY = 1'b1
    } t_cfg_addr;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_FINISH
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic latch;    // capture the accepted request
        logic rd_en;    // read the link of the head buffer
        logic sweep;    // write one link of the initial chain
        logic finish;   // apply the update and load the result
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        t_req in_req;        // request type on the input bus
        logic sweep_needed;  // initialize must chain two or more buffers
        logic sweep_last;    // last link of the chain is being written
        logic out_free;      // result register can take a new result
    } t_sts;

endpackage

>>> rtl/core/lbfl_ctrl.sv
// Request sequencer for the linked buffer free list.
// Depends on lbfl_pkg; drives lbfl_dp through command and status structs.
module lbfl_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    input  lbfl_pkg::t_sts i_sts,
    output lbfl_pkg::t_cmd o_cmd
);

    lbfl_pkg::t_state r_state;
    lbfl_pkg::t_state n_state;
    logic             accept;

    assign accept = i_s_tvalid && (r_state == lbfl_pkg::ST_IDLE);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            lbfl_pkg::ST_IDLE: begin
                if (accept) begin
                    if ((i_sts.in_req == lbfl_pkg::REQ_INIT) && i_sts.sweep_needed) begin
                        n_state = lbfl_pkg::ST_SWEEP;
                    end else begin
                        n_state = lbfl_pkg::ST_FINISH;
                    end
                end
            end
            lbfl_pkg::ST_SWEEP: begin
                if (i_sts.sweep_last) begin
                    n_state = lbfl_pkg::ST_FINISH;
                end
            end
            lbfl_pkg::ST_FINISH: begin
                if (i_sts.out_free) begin
                    n_state = lbfl_pkg::ST_IDLE;
                end
            end
            default: n_state = lbfl_pkg::ST_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            lbfl_pkg::ST_IDLE: begin
                o_s_tready  = 1'b1;
                o_cmd.rd_en = 1'b1;
                o_cmd.latch = accept;
            end
            lbfl_pkg::ST_SWEEP: begin
                o_cmd.sweep = 1'b1;
            end
            lbfl_pkg::ST_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= lbfl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

>>> rtl/core/lbfl_dp.sv
// Datapath of the linked buffer free list: link memory, has-next flags,
// list registers, configuration and result register. Depends on lbfl_pkg.
module lbfl_dp (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic                          i_cfg_addr,
    input  logic [lbfl_pkg::CAP_W-1:0]    i_cfg_wdata,
    input  logic [lbfl_pkg::IN_W-1:0]     i_s_tdata,
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [lbfl_pkg::OUT_W-1:0]    o_m_tdata,
    input  lbfl_pkg::t_cmd                i_cmd,
    output lbfl_pkg::t_sts                o_sts
);

    // Configuration
    logic [lbfl_pkg::CNT_W-1:0] r_buffer_count;
    logic [lbfl_pkg::CAP_W-1:0] r_buffer_capacity;

    // Request and list state
    lbfl_pkg::t_req                    r_req;
    logic [lbfl_pkg::IDX_W-1:0]        r_rel;
    logic [lbfl_pkg::IDX_W-1:0]        r_head;
    logic [lbfl_pkg::IDX_W-1:0]        r_tail;
    logic [lbfl_pkg::CNT_W-1:0]        r_free;
    logic signed [lbfl_pkg::FLT_W-1:0] r_flight;
    logic [lbfl_pkg::POOL_DEPTH-1:0]   r_link_valid;
    logic [lbfl_pkg::IDX_W-1:0]        r_sweep_idx;
    logic [lbfl_pkg::IDX_W-1:0]        r_rd_link;
    logic                              r_rd_valid;
    logic                              r_out_valid;
    logic [lbfl_pkg::OUT_W-1:0]        r_out_data;

    logic [lbfl_pkg::IDX_W-1:0] mem_link [lbfl_pkg::POOL_DEPTH];

    logic [lbfl_pkg::IDX_W-1:0]        n_head;
    logic [lbfl_pkg::IDX_W-1:0]        n_tail;
    logic [lbfl_pkg::CNT_W-1:0]        n_free;
    logic signed [lbfl_pkg::FLT_W-1:0] n_flight;

    logic                         alloc_refuse;
    logic                         init_ok;
    logic [lbfl_pkg::CNT_W-1:0]   cnt_clamp;
    logic [lbfl_pkg::SPAN_W-1:0]  span;
    logic [lbfl_pkg::OFF_W-1:0]   grant_off;
    logic                         out_status;
    logic [lbfl_pkg::IDX_W-1:0]   out_idx;
    logic [lbfl_pkg::OFF_W-1:0]   out_off;
    logic                         mem_we;
    logic [lbfl_pkg::IDX_W-1:0]   mem_waddr;
    logic [lbfl_pkg::IDX_W-1:0]   mem_wdata;

    // Configuration writes keep only each register's width
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_buffer_count    <= lbfl_pkg::COUNT_RESET;
            r_buffer_capacity <= lbfl_pkg::CAPACITY_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (lbfl_pkg::t_cfg_addr'(i_cfg_addr))
                lbfl_pkg::CFG_BUFFER_COUNT:
                    r_buffer_count <= i_cfg_wdata[lbfl_pkg::CNT_W-1:0];
                lbfl_pkg::CFG_BUFFER_CAPACITY:
                    r_buffer_capacity <= i_cfg_wdata;
                default: r_buffer_count <= r_buffer_count;
            endcase
        end
    end

    // Decode checks
    always_comb begin
        init_ok   = (r_buffer_count != '0) && (r_buffer_capacity != '0);
        cnt_clamp = (r_buffer_count > lbfl_pkg::POOL_LIMIT) ? lbfl_pkg::POOL_LIMIT
                                                            : r_buffer_count;
        alloc_refuse = (r_free <= 9'd1)
                    || ({1'b0, r_head} >= r_buffer_count)
                    || !r_rd_valid;
        span      = lbfl_pkg::SPAN_W'(r_buffer_capacity)
                  + lbfl_pkg::SPAN_W'(lbfl_pkg::HEADER_BYTES);
        grant_off = lbfl_pkg::OFF_W'(r_head) * lbfl_pkg::OFF_W'(span);
    end

    assign o_sts.in_req       = lbfl_pkg::t_req'(i_s_tdata[1:0]);
    assign o_sts.sweep_needed = init_ok && (cnt_clamp >= 9'd2);
    assign o_sts.sweep_last   = ({1'b0, r_sweep_idx} == (cnt_clamp - 9'd2));
    assign o_sts.out_free     = !r_out_valid || i_m_tready;

    // Next list state and result fields
    always_comb begin
        n_head     = r_head;
        n_tail     = r_tail;
        n_free     = r_free;
        n_flight   = r_flight;
        out_status = 1'b0;
        out_idx    = '0;
        out_off    = '0;
        unique case (r_req)
            lbfl_pkg::REQ_ALLOC: begin
                if (alloc_refuse) begin
                    out_status = 1'b1;
                end else begin
                    n_head  = r_rd_link;
                    n_free  = r_free - 9'd1;
                    out_idx = r_head;
                    out_off = grant_off;
                    if (r_flight < lbfl_pkg::FLIGHT_MAX) begin
                        n_flight = r_flight + 10'sd1;
                    end
                end
            end
            lbfl_pkg::REQ_RELEASE: begin
                n_tail = r_rel;
                if (r_free < lbfl_pkg::FREE_MAX) begin
                    n_free = r_free + 9'd1;
                end
                if (r_flight > lbfl_pkg::FLIGHT_MIN) begin
                    n_flight = r_flight - 10'sd1;
                end
            end
            lbfl_pkg::REQ_INIT: begin
                if (init_ok) begin
                    n_head   = '0;
                    n_tail   = lbfl_pkg::IDX_W'(cnt_clamp - 9'd1);
                    n_free   = cnt_clamp;
                    n_flight = '0;
                end
            end
            lbfl_pkg::REQ_NOP: begin
                n_head = r_head;
            end
            default: n_head = r_head;
        endcase
    end

    // Link memory write port: chain sweep or release
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_sweep_idx;
        mem_wdata = r_sweep_idx + 8'd1;
        if (i_cmd.sweep) begin
            mem_we = 1'b1;
        end else if (i_cmd.finish && (r_req == lbfl_pkg::REQ_RELEASE)) begin
            mem_we    = 1'b1;
            mem_waddr = r_tail;
            mem_wdata = r_rel;
        end
    end

    // Read the link and the has-next flag of the head buffer
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_link[mem_waddr] <= mem_wdata;
        end
        if (i_cmd.rd_en) begin
            r_rd_link  <= mem_link[r_head];
            r_rd_valid <= r_link_valid[r_head];
        end
    end

    // Capture request, step the sweep
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req <= lbfl_pkg::t_req'(i_s_tdata[1:0]);
            r_rel <= i_s_tdata[9:2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_idx <= '0;
        end else if (i_cmd.latch) begin
            r_sweep_idx <= '0;
        end else if (i_cmd.sweep) begin
            r_sweep_idx <= r_sweep_idx + 8'd1;
        end
    end

    // List registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head   <= '0;
            r_tail   <= lbfl_pkg::TAIL_RESET;
            r_free   <= '0;
            r_flight <= '0;
        end else if (i_cmd.finish) begin
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_free   <= n_free;
            r_flight <= n_flight;
        end
    end

    // Has-next flags: set one per sweep cycle, at most one update per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_link_valid <= '0;
        end else if (i_cmd.sweep) begin
            r_link_valid[r_sweep_idx] <= 1'b1;
        end else if (i_cmd.finish) begin
            unique case (r_req)
                lbfl_pkg::REQ_ALLOC: begin
                    if (!alloc_refuse) begin
                        r_link_valid[r_head] <= 1'b0;
                    end
                end
                lbfl_pkg::REQ_RELEASE: begin
                    r_link_valid[r_tail] <= 1'b1;
                end
                lbfl_pkg::REQ_INIT: begin
                    if (init_ok) begin
                        r_link_valid[lbfl_pkg::IDX_W'(cnt_clamp - 9'd1)] <= 1'b0;
                    end
                end
                lbfl_pkg::REQ_NOP: ;
                default: ;
            endcase
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            r_out_data <= {3'b000, n_flight, n_free, out_off, out_idx, out_status};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

>>> rtl/core/linked_buffer_free_list.sv
// Linked buffer free list, top level: sequencer plus datapath.
// Depends on lbfl_pkg, lbfl_ctrl, lbfl_dp and linked_buffer_free_list_defines.svh.
//
// Usage:
//   Requests arrive on the slave stream (allocate, release, initialize);
//   each produces exactly one result on the master stream with status,
//   granted index and byte offset, free count and outstanding count.
//   Allocate and release pass through an accept step, which reads the head's
//   link and has-next flag, and an update step, which updates the list and
//   loads the result register. Initialize passes through the accept step, a
//   sweep that writes the links of the chain one by one and the update step;
//   the sweep is skipped when it chains one buffer or none.
//   One request is handled at a time; the slave side is ready again as soon
//   as the result is loaded, so a waiting result does not block the next
//   request. If the receiver stalls, a finished request waits in place
//   until the result register empties.
//   Configuration registers (buffer_count, buffer_capacity) must be written
//   via the cfg port while no request is in progress; not enforced by the block.
//   Reset is synchronous: the list is empty (free count zero) until an
//   initialize request; configuration returns to 256 buffers of 4096 bytes.
`include "linked_buffer_free_list_defines.svh"

module linked_buffer_free_list (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // cfg: index 0 buffer_count, index 1 buffer_capacity
    input  logic                       i_cfg_wr_en,
    input  logic                       i_cfg_addr,
    input  logic [lbfl_pkg::CAP_W-1:0] i_cfg_wdata,
    input  logic                       i_s_tvalid,
    output logic                       o_s_tready,
    // tdata: req_type[1:0], release_index[9:2], zero fill [15:10]
    input  logic [lbfl_pkg::IN_W-1:0]  i_s_tdata,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    // tdata: status[0], granted_index[8:1], granted_offset[33:9],
    //        free_count[42:34], outstanding[52:43], zero fill [55:53]
    output logic [lbfl_pkg::OUT_W-1:0] o_m_tdata
);

    lbfl_pkg::t_cmd cmd;
    lbfl_pkg::t_sts sts;

    logic signed [lbfl_pkg::FLT_W-1:0] out_flight;
    logic                              flight_ok;

    lbfl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    lbfl_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

    // Outstanding field of the result and its range check
    assign out_flight = o_m_tdata[52:43];
    assign flight_ok  = (out_flight >= lbfl_pkg::FLIGHT_MIN)
                     && (out_flight <= lbfl_pkg::FLIGHT_MAX);

    // One request in progress at a time
    `LBFL_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, i_s_tvalid && o_s_tready, !o_s_tready)
    // Free count never passes the pool size
    `LBFL_ASSERT_NOW(a_free_bound, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[42:34] <= 9'd256)
    // Outstanding count stays within its saturation limits
    `LBFL_ASSERT_NOW(a_flight_bound, i_clk, i_rst_n, o_m_tvalid, flight_ok)
    // A refused allocate grants nothing
    `LBFL_ASSERT_NOW(a_refuse_zero, i_clk, i_rst_n, o_m_tvalid && o_m_tdata[0], o_m_tdata[33:1] == 33'd0)

endmodule

>>> tb/tb.sv
// Self-checking testbench for linked_buffer_free_list: directed and random request
// traffic, a request-level predictor of the free list, and a checker of every result.
// Depends on lbfl_pkg and the linked_buffer_free_list RTL.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lbfl_pkg::*;

    localparam int QUIET_LIMIT = 3000;
    localparam int SETTLE_CYCLES = 4;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] index;
        logic [OFF_W-1:0] offset;
        logic [CNT_W-1:0] free_cnt;
        logic [FLT_W-1:0] outstanding;
    } t_grant;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic              cfg_addr = 1'b0;
    logic [CAP_W-1:0]  cfg_wdata = '0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b1;
    logic [OUT_W-1:0]  m_tdata;

    // Free list as the block should see it
    logic [IDX_W-1:0] link_of [POOL_DEPTH];
    bit               has_link [POOL_DEPTH];
    logic [IDX_W-1:0] head_buf = '0;
    logic [IDX_W-1:0] tail_buf = TAIL_RESET;
    int               free_bufs = 0;
    int               in_use = 0;
    int               pool_count = 256;
    int               buf_bytes = 4096;
    logic [IDX_W-1:0] held_bufs [$];
    t_grant           pending_grants [$];

    bit idle_on = 1'b0;
    bit stall_on = 1'b0;
    int stall_left = 0;
    int quiet_cycles = 0;
    int err_count = 0;
    int n_sent = 0;
    int n_granted = 0;
    int n_refused = 0;
    int n_checked = 0;

    linked_buffer_free_list DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_addr  (cfg_addr),
        .i_cfg_wdata (cfg_wdata),
        .i_s_tvalid  (s_tvalid),
        .o_s_tready  (s_tready),
        // tdata: req_type[1:0], release_index[9:2], zero fill [15:10]
        .i_s_tdata   (s_tdata),
        .o_m_tvalid  (m_tvalid),
        .i_m_tready  (m_tready),
        // tdata: status[0], granted_index[8:1], granted_offset[33:9],
        //        free_count[42:34], outstanding[52:43], zero fill [55:53]
        .o_m_tdata   (m_tdata)
    );

    always #1 clk = ~clk;

    // Mostly short pauses, now and then a long one
    function automatic int pick_pause();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return $urandom_range(1, 3);
        if (r < 92) return $urandom_range(4, 8);
        return $urandom_range(12, 40);
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endfunction

    // Advance the free list by one request and queue the result it must give
    task automatic predict_grant(input t_req req, input logic [IDX_W-1:0] rel_idx);
        t_grant           g;
        logic [IDX_W-1:0] h;
        int               cnt;
        int               found [$];
        g = '0;
        case (req)
            REQ_ALLOC: begin
                h = head_buf;
                if (free_bufs <= 1 || int'(h) >= pool_count || !has_link[h]) begin
                    g.status = 1'b1;
                    n_refused++;
                end else begin
                    head_buf = link_of[h];
                    has_link[h] = 1'b0;
                    free_bufs--;
                    if (in_use < 256) in_use++;
                    g.index = h;
                    g.offset = OFF_W'(int'(h) * (buf_bytes + HEADER_BYTES));
                    held_bufs.push_back(h);
                    n_granted++;
                end
            end
            REQ_RELEASE: begin
                link_of[tail_buf] = rel_idx;
                has_link[tail_buf] = 1'b1;
                tail_buf = rel_idx;
                if (free_bufs < 256) free_bufs++;
                if (in_use > -256) in_use--;
                found = held_bufs.find_first_index(x) with (x == rel_idx);
                if (found.size() > 0) held_bufs.delete(found[0]);
            end
            REQ_INIT: begin
                if (pool_count != 0 && buf_bytes != 0) begin
                    cnt = (pool_count > POOL_LIMIT_INT) ? POOL_LIMIT_INT : pool_count;
                    for (int i = 0; i < cnt - 1; i++) begin
                        link_of[i] = IDX_W'(i + 1);
                        has_link[i] = 1'b1;
                    end
                    has_link[cnt - 1] = 1'b0;
                    head_buf = '0;
                    tail_buf = IDX_W'(cnt - 1);
                    free_bufs = cnt;
                    in_use = 0;
                    held_bufs.delete();
                end
            end
            default: ;
        endcase
        g.free_cnt = CNT_W'(free_bufs);
        g.outstanding = FLT_W'(in_use);
        pending_grants.push_back(g);
    endtask

    // Present one request and hold it until the transaction completes
    task automatic send_request(input t_req req, input logic [IDX_W-1:0] rel_idx);
        int gap;
        gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {6'd0, rel_idx, 2'(req)};
        do @(posedge clk); while (!s_tready);
        predict_grant(req, rel_idx);
        n_sent++;
    endtask

    // Drop valid and wait until every result is back and the block is idle
    task automatic settle_block();
        s_tvalid <= 1'b0;
        while (pending_grants.size() > 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input t_cfg_addr addr, input logic [CAP_W-1:0] value);
        cfg_wr_en <= 1'b1;
        cfg_addr <= addr;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
        if (addr == CFG_BUFFER_COUNT) pool_count = int'(value[CNT_W-1:0]);
        else buf_bytes = int'(value);
    endtask

    // Empty list after reset, then a head without a link while two are free
    task automatic test_empty_list();
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_NOP, 8'hA5);
        send_request(REQ_RELEASE, 8'd5);
        send_request(REQ_RELEASE, 8'd6);
        send_request(REQ_ALLOC, 8'd0);
    endtask

    // Small pool: grants, last-buffer refusal, extreme release indexes, head outside pool
    task automatic test_small_pool();
        settle_block();
        write_cfg(CFG_BUFFER_COUNT, 16'd3);
        write_cfg(CFG_BUFFER_CAPACITY, 16'hFFFF);
        send_request(REQ_INIT, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_RELEASE, 8'd255);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_RELEASE, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
    endtask

    // Initialize with zero count, then zero capacity: both leave the list alone
    task automatic test_init_ignored();
        settle_block();
        write_cfg(CFG_BUFFER_COUNT, 16'd0);
        send_request(REQ_INIT, 8'd0);
        settle_block();
        write_cfg(CFG_BUFFER_COUNT, 16'd5);
        write_cfg(CFG_BUFFER_CAPACITY, 16'd0);
        send_request(REQ_INIT, 8'd0);
    endtask

    // Oversized count clamps to the pool; upper write bits are dropped
    task automatic test_init_clamp();
        settle_block();
        write_cfg(CFG_BUFFER_COUNT, 16'hFFFF);
        write_cfg(CFG_BUFFER_CAPACITY, 16'd1);
        send_request(REQ_INIT, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_NOP, 8'd0);
    endtask

    // One-buffer pool never grants
    task automatic test_single_buffer();
        settle_block();
        write_cfg(CFG_BUFFER_COUNT, 16'd1);
        write_cfg(CFG_BUFFER_CAPACITY, 16'd4096);
        send_request(REQ_INIT, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
    endtask

    // Flood with releases until free count and outstanding both saturate
    task automatic test_release_saturation();
        settle_block();
        write_cfg(CFG_BUFFER_COUNT, 16'd256);
        idle_on = 1'b1;
        stall_on = 1'b1;
        send_request(REQ_INIT, 8'd0);
        repeat (300) send_request(REQ_RELEASE, 8'($urandom_range(0, 255)));
        send_request(REQ_ALLOC, 8'd0);
        send_request(REQ_ALLOC, 8'd0);
    endtask

    // Phases of mixed traffic, mostly releasing buffers that were granted
    task automatic test_random_traffic();
        logic [CAP_W-1:0] cnt_val;
        logic [CAP_W-1:0] cap_val;
        logic [IDX_W-1:0] rel_idx;
        t_req             req;
        int               alloc_pct;
        int               r;
        alloc_pct = 50;
        for (int p = 0; p < 7; p++) begin
            case (p)
                0: begin cnt_val = 16'd256;  cap_val = 16'd4096;  end
                1: begin cnt_val = 16'd2;    cap_val = 16'hFFFF;  end
                2: begin cnt_val = 16'd1;    cap_val = 16'd1;     end
                3: begin cnt_val = 16'd40;   cap_val = 16'd1000;  end
                4: begin cnt_val = 16'hFE10; cap_val = 16'd300;   end
                5: begin cnt_val = 16'd256;  cap_val = 16'hFFFF;  end
                default: begin cnt_val = 16'd7; cap_val = 16'd0;  end
            endcase
            settle_block();
            write_cfg(CFG_BUFFER_COUNT, cnt_val);
            write_cfg(CFG_BUFFER_CAPACITY, cap_val);
            send_request(REQ_INIT, 8'($urandom_range(0, 255)));
            for (int k = 0; k < 100; k++) begin
                if (k % 35 == 0) begin
                    alloc_pct = $urandom_range(25, 70);
                    idle_on = ($urandom_range(0, 3) != 0);
                    stall_on = ($urandom_range(0, 3) != 0);
                end
                r = $urandom_range(0, 99);
                if (r < alloc_pct) req = REQ_ALLOC;
                else if (r < 94) req = REQ_RELEASE;
                else if (r < 98) req = REQ_INIT;
                else req = REQ_NOP;
                rel_idx = 8'($urandom_range(0, 255));
                if (req == REQ_RELEASE && held_bufs.size() > 0 && $urandom_range(0, 3) != 0)
                    rel_idx = held_bufs[$urandom_range(0, held_bufs.size() - 1)];
                send_request(req, rel_idx);
            end
        end
    endtask

    initial begin
        for (int i = 0; i < POOL_DEPTH; i++) begin
            link_of[i] = '0;
            has_link[i] = 1'b0;
        end
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_small_pool();
        test_init_ignored();
        test_init_clamp();
        test_single_buffer();
        test_release_saturation();
        test_random_traffic();
        settle_block();

        $display("Sent %0d requests over seven pool settings; %0d grants, %0d refusals.",
                 n_sent, n_granted, n_refused);
        $display("Checked %0d results field by field, %0d mismatches.", n_checked, err_count);
        if (err_count == 0) begin
            $display("PASS linked_buffer_free_list");
        end else begin
            $display("FAIL linked_buffer_free_list");
        end
        $finish;
    end

    // Stall the result side at random
    always @(posedge clk) begin
        if (stall_left > 0) begin
            stall_left = stall_left - 1;
            m_tready <= 1'b0;
        end else if (stall_on && $urandom_range(0, 99) < 25) begin
            stall_left = pick_pause() - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge clk) begin : check_results
        t_grant got;
        t_grant want;
        if (rst_n && m_tvalid && m_tready) begin
            got.status = m_tdata[0];
            got.index = m_tdata[8:1];
            got.offset = m_tdata[33:9];
            got.free_cnt = m_tdata[42:34];
            got.outstanding = m_tdata[52:43];
            n_checked++;
            if (pending_grants.size() == 0) begin
                $error("result transaction with no request outstanding");
                err_count++;
            end else begin
                want = pending_grants.pop_front();
                check_field("status", want.status, got.status);
                check_field("granted_index", want.index, got.index);
                check_field("granted_offset", want.offset, got.offset);
                check_field("free_count", want.free_cnt, got.free_cnt);
                check_field("outstanding", $signed(want.outstanding), $signed(got.outstanding));
            end
        end
    end

    // End the run when work is pending but nothing moves for too long
    always @(posedge clk) begin
        if (rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) ||
                !(s_tvalid || pending_grants.size() > 0)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Timeout: no transaction for %0d cycles.", QUIET_LIMIT);
                $display("FAIL linked_buffer_free_list");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
+incdir+rtl/core
rtl/core/lbfl_pkg.sv
rtl/core/lbfl_ctrl.sv
rtl/core/lbfl_dp.sv
rtl/core/linked_buffer_free_list.sv
tb/tb.sv
